@@ hw/rtl/crcfr_pkg.sv @@
// Package for the CRC-checked frame receiver: sizes, positions, register
// indexes, the CRC byte update and the structs passed between the parser
// and the frame queue. No dependencies.
package crcfr_pkg;

   localparam int PAYLOAD_BYTES = 17;
   localparam int QUEUE_FRAMES  = 8;

   localparam int IDX_W   = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int SLOT_W  = (QUEUE_FRAMES > 1) ? $clog2(QUEUE_FRAMES) : 1;
   localparam int COUNT_W = $clog2(QUEUE_FRAMES + 1);
   localparam int POS_W   = $clog2(PAYLOAD_BYTES + 4);
   localparam int QUEUE_DEPTH = QUEUE_FRAMES * PAYLOAD_BYTES;
   localparam int ADDR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [POS_W-1:0] POS_IDLE         = POS_W'(0);
   localparam logic [POS_W-1:0] POS_FIRST_DATA   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LAST_DATA    = POS_W'(PAYLOAD_BYTES);
   localparam logic [POS_W-1:0] POS_CRC_HI       = POS_W'(PAYLOAD_BYTES + 1);
   localparam logic [POS_W-1:0] POS_CRC_LO       = POS_W'(PAYLOAD_BYTES + 2);
   localparam logic [POS_W-1:0] POS_END          = POS_W'(PAYLOAD_BYTES + 3);

   localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(PAYLOAD_BYTES - 1);
   localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(QUEUE_FRAMES - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_FRAMES);

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARKER  = 1'b1;

   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
   localparam logic [7:0]  MARKER_RESET   = 8'h61;
   localparam logic [15:0] IDLE_MAX       = 16'hFFFF;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [7:0]       data;
      logic             commit;
   } wr_type;

   // CRC-16/CCITT-FALSE update by one byte, most significant bit first.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0]  x;
      logic [15:0] x16;
      x   = crc[15:8] ^ b;
      x   = x ^ (x >> 4);
      x16 = {8'h00, x};
      return (crc << 8) ^ (x16 << 12) ^ (x16 << 5) ^ x16;
   endfunction

endpackage

@@ hw/rtl/crcfr_req_if.sv @@
// Request channel of the frame receiver: one received byte or one tick per
// transaction. Depends on nothing.
interface crcfr_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source(output valid, output cmd, output rx_byte, input ready);
   modport sink(input valid, input cmd, input rx_byte, output ready);
endinterface

@@ hw/rtl/crcfr_rsp_if.sv @@
// Response channel of the frame receiver: one payload byte per transaction,
// with the last flag. Depends on nothing.
interface crcfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       last;

   modport source(output valid, output payload_byte, output last, input ready);
   modport sink(input valid, input payload_byte, input last, output ready);
endinterface

@@ hw/rtl/crcfr_front.sv @@
// Front of the frame receiver: configuration registers, frame parser, CRC
// and idle timeout. Uses crcfr_pkg and crcfr_req_if.
module crcfr_front (
   input  logic                                clock,
   input  logic                                reset,
   crcfr_req_if.sink                           req,
   input  logic                                csr_write_en,
   input  logic [crcfr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [crcfr_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                                queue_full,
   output crcfr_pkg::wr_type                   wr
);

   logic [crcfr_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [15:0]                 crc_ff, crc_in;
   logic [7:0]                  crc_hi_ff, crc_hi_in;
   logic                        crc_ok_ff, crc_ok_in;
   logic [15:0]                 idle_ff, idle_in;
   logic [15:0]                 timeout_ff, timeout_in;
   logic [7:0]                  marker_ff, marker_in;
   logic                        in_payload;
   logic                        accept;
   logic [15:0]                 limit;
   logic [15:0]                 idle_sat;
   logic [crcfr_pkg::POS_W-1:0] pos_less;

   assign in_payload = (pos_ff >= crcfr_pkg::POS_FIRST_DATA) &&
                       (pos_ff <= crcfr_pkg::POS_LAST_DATA);
   assign req.ready  = !(in_payload && queue_full);
   assign accept     = req.valid && req.ready;
   assign limit      = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;
   assign idle_sat   = (idle_ff == crcfr_pkg::IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
   assign pos_less   = pos_ff - crcfr_pkg::POS_W'(1);

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      crc_hi_in  = crc_hi_ff;
      crc_ok_in  = crc_ok_ff;
      idle_in    = idle_ff;
      timeout_in = timeout_ff;
      marker_in  = marker_ff;
      wr.en      = 1'b0;
      wr.idx     = pos_less[crcfr_pkg::IDX_W-1:0];
      wr.data    = req.rx_byte;
      wr.commit  = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            crcfr_pkg::CSR_TIMEOUT: timeout_in = csr_write_data[15:0];
            crcfr_pkg::CSR_MARKER:  marker_in  = csr_write_data[7:0];
            default: ;
         endcase
      end
      if (accept) begin
         if (req.cmd == crcfr_pkg::CMD_TICK) begin
            if (idle_sat >= limit) begin
               pos_in  = crcfr_pkg::POS_IDLE;
               idle_in = 16'd0;
            end else begin
               idle_in = idle_sat;
            end
         end else begin
            idle_in = 16'd0;
            if (pos_ff == crcfr_pkg::POS_IDLE) begin
               if (req.rx_byte == marker_ff) begin
                  crc_in = crcfr_pkg::crc_feed(crcfr_pkg::CRC_INIT, req.rx_byte);
                  pos_in = crcfr_pkg::POS_FIRST_DATA;
               end
            end else if (in_payload) begin
               wr.en  = 1'b1;
               crc_in = crcfr_pkg::crc_feed(crc_ff, req.rx_byte);
               pos_in = pos_ff + crcfr_pkg::POS_W'(1);
            end else if (pos_ff == crcfr_pkg::POS_CRC_HI) begin
               crc_hi_in = req.rx_byte;
               pos_in    = pos_ff + crcfr_pkg::POS_W'(1);
            end else if (pos_ff == crcfr_pkg::POS_CRC_LO) begin
               crc_ok_in = ({crc_hi_ff, req.rx_byte} == crc_ff);
               pos_in    = pos_ff + crcfr_pkg::POS_W'(1);
            end else begin
               wr.commit = crc_ok_ff;
               pos_in    = crcfr_pkg::POS_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= crcfr_pkg::POS_IDLE;
         crc_ff     <= crcfr_pkg::CRC_INIT;
         crc_hi_ff  <= 8'h00;
         crc_ok_ff  <= 1'b0;
         idle_ff    <= 16'd0;
         timeout_ff <= crcfr_pkg::TIMEOUT_RESET;
         marker_ff  <= crcfr_pkg::MARKER_RESET;
      end else begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         crc_hi_ff  <= crc_hi_in;
         crc_ok_ff  <= crc_ok_in;
         idle_ff    <= idle_in;
         timeout_ff <= timeout_in;
         marker_ff  <= marker_in;
      end
   end

`ifndef SYNTHESIS
   a_write_has_room: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> !queue_full)
      else $error("payload byte written while every queue slot is taken");
   a_commit_ends_frame: assert property (@(posedge clock) disable iff (reset)
      wr.commit |=> (pos_ff == crcfr_pkg::POS_IDLE) && (idle_ff == 16'd0))
      else $error("parser did not return to waiting after a committed frame");
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= crcfr_pkg::POS_END)
      else $error("frame position beyond the end byte");
`endif

endmodule

@@ hw/rtl/crcfr_queue.sv @@
// Back of the frame receiver: frame queue memory, slot pointers and the
// byte emitter that drives the response channel. Uses crcfr_pkg and crcfr_rsp_if.
module crcfr_queue (
   input  logic              clock,
   input  logic              reset,
   input  crcfr_pkg::wr_type wr,
   output logic              queue_full,
   crcfr_rsp_if.source       rsp
);

   logic [7:0] mem [crcfr_pkg::QUEUE_DEPTH];

   logic [crcfr_pkg::SLOT_W-1:0]  head_ff, head_in;
   logic [crcfr_pkg::SLOT_W-1:0]  tail_ff, tail_in;
   logic [crcfr_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [crcfr_pkg::IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rd_data_ff;
   logic                          last_ff;
   logic                          advance;
   logic                          rd_en;
   logic                          rd_last;
   logic                          pop;
   logic [crcfr_pkg::ADDR_W-1:0]  wr_addr;
   logic [crcfr_pkg::ADDR_W-1:0]  rd_addr;

   assign queue_full = (count_ff == crcfr_pkg::FULL_COUNT);
   assign advance    = !rsp_valid_ff || rsp.ready;
   assign rd_en      = advance && (count_ff != crcfr_pkg::COUNT_W'(0));
   assign rd_last    = (rd_idx_ff == crcfr_pkg::LAST_IDX);
   assign pop        = rd_en && rd_last;

   assign wr_addr = crcfr_pkg::ADDR_W'(tail_ff) * crcfr_pkg::ADDR_W'(crcfr_pkg::PAYLOAD_BYTES)
                    + crcfr_pkg::ADDR_W'(wr.idx);
   assign rd_addr = crcfr_pkg::ADDR_W'(head_ff) * crcfr_pkg::ADDR_W'(crcfr_pkg::PAYLOAD_BYTES)
                    + crcfr_pkg::ADDR_W'(rd_idx_ff);

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      count_in     = count_ff;
      if (advance) begin
         rsp_valid_in = rd_en;
      end
      if (rd_en) begin
         if (rd_last) begin
            rd_idx_in = '0;
            head_in   = (head_ff == crcfr_pkg::LAST_SLOT) ? '0
                        : head_ff + crcfr_pkg::SLOT_W'(1);
         end else begin
            rd_idx_in = rd_idx_ff + crcfr_pkg::IDX_W'(1);
         end
      end
      if (wr.commit) begin
         tail_in = (tail_ff == crcfr_pkg::LAST_SLOT) ? '0
                   : tail_ff + crcfr_pkg::SLOT_W'(1);
      end
      if (wr.commit && !pop) begin
         count_in = count_ff + crcfr_pkg::COUNT_W'(1);
      end else if (pop && !wr.commit) begin
         count_in = count_ff - crcfr_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         last_ff    <= rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.payload_byte = rd_data_ff;
   assign rsp.last         = last_ff;

`ifndef SYNTHESIS
   a_commit_not_full: assert property (@(posedge clock) disable iff (reset)
      wr.commit |-> !queue_full)
      else $error("frame committed into a full queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= crcfr_pkg::FULL_COUNT)
      else $error("queued frame count exceeds the number of slots");
   a_mid_frame_has_frame: assert property (@(posedge clock) disable iff (reset)
      (rd_idx_ff != '0) |-> (count_ff != crcfr_pkg::COUNT_W'(0)))
      else $error("read position inside a frame while no frame is queued");
`endif

endmodule

@@ hw/rtl/crc_checked_frame_receiver.sv @@
// The parser front takes one request transaction per clock: each byte goes
// through a one-byte-per-clock CRC-16/CCITT-FALSE update, and payload bytes
// are written straight into the tail slot of an eight-frame queue memory. A
// frame that passes its check is released when its end byte is taken, and
// its 17 payload bytes leave one per clock from the registered memory read
// whenever the response side is ready. Request transactions, bytes
// and ticks alike, stall only while the parser is inside a frame's payload
// and all eight slots still hold frames waiting to be delivered. There is no
// clearing pass after reset.
//
// Top level of the CRC-checked frame receiver. Uses crcfr_pkg, crcfr_req_if,
// crcfr_rsp_if, crcfr_front and crcfr_queue.
module crc_checked_frame_receiver (
   input  logic                              clock,
   input  logic                              reset,
   crcfr_req_if.sink                         req,
   crcfr_rsp_if.source                       rsp,
   input  logic                              csr_write_en,
   input  logic [crcfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [crcfr_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   crcfr_pkg::wr_type wr;
   logic              queue_full;

   crcfr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .queue_full     (queue_full),
      .wr             (wr)
   );

   crcfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .queue_full (queue_full),
      .rsp        (rsp)
   );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for crc_checked_frame_receiver: drives byte and tick
// transactions, predicts the delivered payload bytes and checks them in order.
// Depends on crcfr_pkg, crcfr_req_if, crcfr_rsp_if and the receiver RTL.
module testbench;

   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 600;
   localparam int RUN_LIMIT_NS  = 2_000_000;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last;
   } payload_beat_type;

   class frame_tracker_type;
      logic [15:0]                 timeout_limit;
      logic [7:0]                  marker;
      logic [crcfr_pkg::POS_W-1:0] position;
      logic [15:0]                 crc;
      logic [7:0]                  crc_hi;
      bit                          crc_bad;
      logic [7:0]                  store [crcfr_pkg::PAYLOAD_BYTES];
      logic [15:0]                 idle_count;
      payload_beat_type            awaited [$];
      int                          errors;
      int                          checked;
      int                          good_frames;
      int                          bad_frames;
      int                          abandoned;

      static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
         logic [15:0] r;
         r = c ^ {b, 8'h00};
         for (int k = 0; k < 8; k++)
            r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
         return r;
      endfunction

      function void clear();
         timeout_limit = crcfr_pkg::TIMEOUT_RESET;
         marker        = crcfr_pkg::MARKER_RESET;
         position      = crcfr_pkg::POS_IDLE;
         crc           = crcfr_pkg::CRC_INIT;
         crc_hi        = 8'h00;
         crc_bad       = 1'b0;
         idle_count    = 16'h0000;
         awaited.delete();
         errors        = 0;
         checked       = 0;
         good_frames   = 0;
         bad_frames    = 0;
         abandoned     = 0;
      endfunction

      function void set_config(logic [15:0] timeout, logic [7:0] start_byte);
         timeout_limit = timeout;
         marker        = start_byte;
      endfunction

      function void take_request(logic cmd, logic [7:0] data);
         logic [15:0]                 limit;
         logic [crcfr_pkg::POS_W-1:0] pos_less;
         logic [crcfr_pkg::IDX_W-1:0] slot;
         if (cmd == crcfr_pkg::CMD_TICK) begin
            limit = (timeout_limit == 16'h0000) ? 16'h0001 : timeout_limit;
            if (idle_count != crcfr_pkg::IDLE_MAX)
               idle_count = idle_count + 16'd1;
            if (idle_count >= limit) begin
               if (position != crcfr_pkg::POS_IDLE)
                  abandoned++;
               position   = crcfr_pkg::POS_IDLE;
               idle_count = 16'h0000;
            end
            return;
         end
         idle_count = 16'h0000;
         if (position == crcfr_pkg::POS_IDLE) begin
            if (data == marker) begin
               crc      = crc_step(crcfr_pkg::CRC_INIT, data);
               position = crcfr_pkg::POS_FIRST_DATA;
            end
         end else if (position <= crcfr_pkg::POS_LAST_DATA) begin
            pos_less    = position - crcfr_pkg::POS_W'(1);
            slot        = pos_less[crcfr_pkg::IDX_W-1:0];
            store[slot] = data;
            crc         = crc_step(crc, data);
            position    = position + crcfr_pkg::POS_W'(1);
         end else if (position == crcfr_pkg::POS_CRC_HI) begin
            crc_hi   = data;
            position = position + crcfr_pkg::POS_W'(1);
         end else if (position == crcfr_pkg::POS_CRC_LO) begin
            crc_bad  = ({crc_hi, data} != crc);
            position = position + crcfr_pkg::POS_W'(1);
         end else begin
            position = crcfr_pkg::POS_IDLE;
            if (crc_bad) begin
               bad_frames++;
            end else begin
               good_frames++;
               for (int k = 0; k < crcfr_pkg::PAYLOAD_BYTES; k++)
                  awaited.push_back('{payload_byte: store[k],
                                      last: (k == crcfr_pkg::PAYLOAD_BYTES - 1)});
            end
         end
      endfunction

      function void check_payload(logic [7:0] data, logic last);
         payload_beat_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected payload byte %02h, last %b", $time, data, last);
            errors++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (data !== want.payload_byte) begin
            $display("%0t: payload byte expected %02h, got %02h",
                     $time, want.payload_byte, data);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last flag expected %b, got %b", $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              csr_write_en;
   logic [crcfr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [crcfr_pkg::CSR_DATA_W-1:0]  csr_write_data;

   crcfr_req_if req_bus();
   crcfr_rsp_if rsp_bus();

   frame_tracker_type book;
   bit                steady;
   bit                hold_request;
   logic [15:0]       frame_timeout;
   logic [7:0]        frame_marker;
   int                config_writes;

   crc_checked_frame_receiver dut (
      .clock          (clock),
      .reset          (reset),
      .req            (req_bus),
      .rsp            (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("testbench: done, errors");
      $finish;
   end

   // The receiver checks each delivered transaction and chooses its ready for the next cycle.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            book.check_payload(rsp_bus.payload_byte, rsp_bus.last);
         if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= 22);
         end
      end
   end

   task automatic send_item(input logic cmd, input logic [7:0] data);
      while (!steady && $urandom_range(99) < 22) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.cmd     <= cmd;
      req_bus.rx_byte <= data;
      do
         @(posedge clock);
      while (!req_bus.ready);
      book.take_request(cmd, data);
   endtask

   task automatic set_config(input logic [15:0] timeout, input logic [7:0] start_byte);
      csr_write_en   <= 1'b1;
      csr_index      <= crcfr_pkg::CSR_TIMEOUT;
      csr_write_data <= timeout;
      @(posedge clock);
      csr_index      <= crcfr_pkg::CSR_MARKER;
      csr_write_data <= {8'($urandom_range(255)), start_byte};
      @(posedge clock);
      csr_write_en   <= 1'b0;
      book.set_config(timeout, start_byte);
      frame_timeout  = timeout;
      frame_marker   = start_byte;
      config_writes += 2;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (book.awaited.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic maybe_ticks();
      int n;
      n = 0;
      if (frame_timeout > 16'd1 && $urandom_range(9) == 0)
         n = (frame_timeout <= 16'd41) ? $urandom_range(1, frame_timeout - 1)
                                       : $urandom_range(1, 4);
      repeat (n) send_item(crcfr_pkg::CMD_TICK, 8'($urandom_range(255)));
   endtask

   task automatic flush_ticks();
      repeat ((frame_timeout == 16'd0) ? 1 : frame_timeout)
         send_item(crcfr_pkg::CMD_TICK, 8'($urandom_range(255)));
   endtask

   task automatic send_frame(input bit corrupt, input bit fixed_body);
      logic [15:0] check;
      logic [7:0]  data;
      check = frame_tracker_type::crc_step(crcfr_pkg::CRC_INIT, frame_marker);
      send_item(crcfr_pkg::CMD_BYTE, frame_marker);
      for (int k = 0; k < crcfr_pkg::PAYLOAD_BYTES; k++) begin
         if (fixed_body) begin
            data = (k % 2) ? 8'hFF : 8'h00;
         end else begin
            case ($urandom_range(6))
               0: data = 8'h00;
               1: data = 8'hFF;
               default: data = 8'($urandom_range(255));
            endcase
         end
         check = frame_tracker_type::crc_step(check, data);
         maybe_ticks();
         send_item(crcfr_pkg::CMD_BYTE, data);
      end
      if (corrupt)
         check = check ^ (16'd1 << $urandom_range(15));
      maybe_ticks();
      send_item(crcfr_pkg::CMD_BYTE, check[15:8]);
      send_item(crcfr_pkg::CMD_BYTE, check[7:0]);
      send_item(crcfr_pkg::CMD_BYTE, 8'($urandom_range(255)));
   endtask

   task automatic send_broken();
      send_item(crcfr_pkg::CMD_BYTE, frame_marker);
      repeat ($urandom_range(1, crcfr_pkg::PAYLOAD_BYTES + 2))
         send_item(crcfr_pkg::CMD_BYTE, 8'($urandom_range(255)));
      flush_ticks();
   endtask

   task automatic random_round();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         send_frame(1'b0, 1'b0);
      end else if (pick < 75) begin
         send_frame(1'b1, 1'b0);
      end else if (pick < 88) begin
         send_broken();
      end else begin
         repeat ($urandom_range(1, 6))
            send_item(($urandom_range(3) == 0) ? crcfr_pkg::CMD_TICK : crcfr_pkg::CMD_BYTE,
                      8'($urandom_range(255)));
         flush_ticks();
      end
   endtask

   initial begin : stimulus
      book = new;
      book.clear();
      steady         = 1'b0;
      hold_request   = 1'b0;
      config_writes  = 0;
      frame_timeout  = crcfr_pkg::TIMEOUT_RESET;
      frame_marker   = crcfr_pkg::MARKER_RESET;
      reset          <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.cmd     <= crcfr_pkg::CMD_BYTE;
      req_bus.rx_byte <= 8'h00;
      csr_write_en   <= 1'b0;
      csr_index      <= crcfr_pkg::CSR_TIMEOUT;
      csr_write_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_item(crcfr_pkg::CMD_BYTE, 8'h00);
      send_item(crcfr_pkg::CMD_BYTE, 8'hFF);
      send_item(crcfr_pkg::CMD_TICK, 8'hFF);
      send_frame(1'b0, 1'b1);
      drain();

      set_config(16'd2, 8'h00);
      send_frame(1'b1, 1'b0);
      send_broken();
      drain();

      // The receiver holds off while more frames arrive than the queue can keep.
      set_config(16'hFFFF, 8'hFF);
      hold_request = 1'b1;
      repeat (crcfr_pkg::QUEUE_FRAMES + 1) send_frame(1'b0, 1'b0);
      drain();

      set_config(16'd0, 8'($urandom_range(255)));
      random_round();
      drain();

      steady = 1'b1;
      set_config(16'($urandom_range(3, 40)), 8'($urandom_range(255)));
      repeat (2) random_round();
      drain();
      steady = 1'b0;

      $display("Covered %0d good and %0d corrupted frames, %0d abandoned on timeout.",
               book.good_frames, book.bad_frames, book.abandoned);
      $display("Checked %0d payload bytes across %0d register writes.",
               book.checked, config_writes);
      if (book.errors == 0 && book.awaited.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

@@ crc_checked_frame_receiver.f @@
hw/rtl/crcfr_pkg.sv
hw/rtl/crcfr_req_if.sv
hw/rtl/crcfr_rsp_if.sv
hw/rtl/crcfr_front.sv
hw/rtl/crcfr_queue.sv
hw/rtl/crc_checked_frame_receiver.sv
tb/testbench.sv
